// ===== design/ultrasonic_echo_ranger_defines.svh =====
// Assertion macros used by the ranger top level.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/uer_pkg.sv =====
// Types, constants and register indexes for the ultrasonic ranger.
`default_nettype none

package uer_pkg;

	localparam int TIME_W   = 32;
	localparam int CNT_W    = 20;
	localparam int SETTLE_W = 20;
	localparam int TRIG_W   = 8;
	localparam int TMO_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	typedef logic [TIME_W-1:0]     time_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SETTLE_W-1:0]   settle_t;
	typedef logic [TRIG_W-1:0]     trig_t;
	typedef logic [TMO_W-1:0]      tmo_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_SETTLE  = 2'd0;
	localparam cfg_idx_t REG_TRIGGER = 2'd1;
	localparam cfg_idx_t REG_TIMEOUT = 2'd2;

	localparam settle_t SETTLE_RST  = 20'd200000;
	localparam trig_t   TRIGGER_RST = 8'd10;
	localparam tmo_t    TIMEOUT_RST = 16'd23200;

	localparam cnt_t CNT_MAX = '1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_SETTLE = 4'b0010,
		PH_TRIG   = 4'b0100,
		PH_WAIT   = 4'b1000
	} phase_t;

	typedef struct packed {
		settle_t settle;
		trig_t   trigger;
		tmo_t    timeout;
	} cfg_t;

	typedef struct packed {
		logic  trigger_out;
		logic  busy;
		logic  done;
		time_t start_time;
		time_t end_time;
		time_t width;
		logic  timed_out;
	} result_t;

endpackage

`default_nettype wire

// ===== design/uer_cfg.sv =====
// Configuration register file: settle, trigger width and timeout.
`default_nettype none

module uer_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire uer_pkg::cfg_idx_t  cfg_index,
	input  wire uer_pkg::cfg_data_t cfg_data,
	output uer_pkg::cfg_t          cfg
);
	import uer_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle  <= SETTLE_RST;
			cfg_q.trigger <= TRIGGER_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SETTLE:  cfg_q.settle  <= cfg_data[SETTLE_W-1:0];
				REG_TRIGGER: cfg_q.trigger <= cfg_data[TRIG_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/uer_core.sv =====
// Ranger sequencer: echo edge capture, phase counter and tick timebase.
`default_nettype none

module uer_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic            start_request,
	input  wire logic            echo_level,
	input  wire uer_pkg::cfg_t   cfg,
	output uer_pkg::result_t     result
);
	import uer_pkg::*;

	phase_t phase_q, phase_d;
	cnt_t   count_q, count_d, count_inc;
	time_t  now_q;
	time_t  start_q, start_d;
	time_t  end_q, end_d;
	logic   valid_q, valid_d;
	logic   done_q, done_d;
	logic   last_echo_q;
	logic   tmo;
	trig_t  trig_len;

	assign count_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + cnt_t'(1);
	assign trig_len  = (cfg.trigger == '0) ? trig_t'(1) : cfg.trigger;

	always_comb begin
		start_d = start_q;
		end_d   = end_q;
		valid_d = valid_q;
		done_d  = done_q;
		phase_d = phase_q;
		count_d = count_q;
		tmo     = 1'b0;

		// capture echo edges only until a full pulse is held
		if (!valid_q) begin
			if (echo_level && !last_echo_q) begin
				start_d = now_q;
			end else if (!echo_level && last_echo_q) begin
				end_d   = now_q;
				valid_d = 1'b1;
			end
		end

		unique case (phase_q)
			PH_SETTLE: begin
				count_d = count_inc;
				if (count_inc >= cnt_t'(cfg.settle)) begin
					phase_d = PH_TRIG;
					count_d = '0;
				end
			end
			PH_TRIG: begin
				count_d = count_inc;
				if (count_inc >= cnt_t'(trig_len)) begin
					phase_d = PH_WAIT;
					count_d = '0;
				end
			end
			PH_WAIT: begin
				if (valid_d) begin
					done_d  = 1'b1;
					phase_d = PH_IDLE;
					count_d = '0;
				end else begin
					count_d = count_inc;
					if (count_inc > cnt_t'(cfg.timeout)) begin
						tmo     = 1'b1;
						phase_d = PH_SETTLE;
						count_d = '0;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_request) begin
					valid_d = 1'b0;
					done_d  = 1'b0;
					phase_d = PH_SETTLE;
					count_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			now_q       <= '0;
			start_q     <= '0;
			end_q       <= '0;
			valid_q     <= 1'b0;
			done_q      <= 1'b0;
			last_echo_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			now_q       <= now_q + time_t'(1);
			start_q     <= start_d;
			end_q       <= end_d;
			valid_q     <= valid_d;
			done_q      <= done_d;
			last_echo_q <= echo_level;
		end
	end

	always_comb begin
		result.trigger_out = (phase_d == PH_TRIG);
		result.busy        = (phase_d != PH_IDLE);
		result.done        = done_d;
		result.start_time  = start_d;
		result.end_time    = end_d;
		result.width       = end_d - start_d;
		result.timed_out   = tmo;
	end

endmodule

`default_nettype wire

// ===== design/uer_out_reg.sv =====
// Result register between the sequencer and the output channel.
`default_nettype none

module uer_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire uer_pkg::result_t result,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  can_load,
	output uer_pkg::result_t      result_q
);
	import uer_pkg::*;

	logic valid_q;

	// free when empty or when the held result leaves this cycle
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

// ===== design/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic ranger: trigger sequencer and echo pulse timer.
`default_nettype none
`include "ultrasonic_echo_ranger_defines.svh"

// Each input transfer is one microsecond tick. The block takes one tick per
// clock cycle: the tick's edge capture, phase count and timestamp update are
// done in the cycle it is accepted, and its result appears on the output
// register in the next cycle. The only thing that holds in_ready low is a
// result in the output register that has not been taken, so the rate is one
// tick per cycle whenever out_ready stays high. Configuration writes are
// always accepted (cfg_ready is always high); indexes beyond the timeout
// register are dropped. Trigger low for the request tick plus settle_us-1
// ticks, high for trigger_us ticks (zero counts as one), then a wait that
// retries once its count passes timeout_us. Phase counters saturate at 2^20-1.
module ultrasonic_echo_ranger (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              start_request,
	input  wire logic              echo_level,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   trigger_out,
	output logic                   busy_res,
	output logic                   done_res,
	output logic [31:0]            echo_start_time,
	output logic [31:0]            echo_end_time,
	output logic [31:0]            pulse_width,
	output logic                   timed_out,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire uer_pkg::cfg_idx_t  cfg_index,
	input  wire uer_pkg::cfg_data_t cfg_data
);
	import uer_pkg::*;

	cfg_t    cfg;
	result_t result;
	result_t result_q;
	logic    can_load;
	logic    advance;

	assign in_ready = can_load;
	assign advance  = in_valid && can_load;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.start_request (start_request),
		.echo_level    (echo_level),
		.cfg           (cfg),
		.result        (result)
	);

	uer_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (can_load),
		.result_q  (result_q)
	);

	assign trigger_out     = result_q.trigger_out;
	assign busy_res        = result_q.busy;
	assign done_res        = result_q.done;
	assign echo_start_time = result_q.start_time[31:0];
	assign echo_end_time   = result_q.end_time[31:0];
	assign pulse_width     = result_q.width[31:0];
	assign timed_out       = result_q.timed_out;

	`UER_ASSERT_NOW(a_trig_busy, out_valid && trigger_out, busy_res, "trigger high while idle")
	`UER_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done while busy")
	`UER_ASSERT_NOW(a_tmo_settle, out_valid && timed_out, busy_res && !trigger_out,
		"timeout outside settle")
	`UER_ASSERT_NEXT(a_width, advance, pulse_width == echo_end_time - echo_start_time,
		"pulse width mismatch")

endmodule

`default_nettype wire

// ===== sim/tb_ultrasonic_echo_ranger.sv =====
// Self-checking testbench for the ultrasonic echo ranger, checked on every result transfer.
module tb_ultrasonic_echo_ranger;
	import uer_pkg::*;

	localparam cfg_idx_t REG_UNUSED = 2'd3;

	// Tracks the ranger tick by tick and holds the readings still owed by the DUT.
	class reading_tracker;
		settle_t settle_reg;
		trig_t   trig_reg;
		tmo_t    tmo_reg;
		phase_t  phase;
		cnt_t    count;
		time_t   tick_now;
		time_t   rise_at;
		time_t   fall_at;
		bit      captured;
		bit      reading_held;
		bit      echo_prev;
		bit      last_tmo;
		result_t due[$];
		int      errors;

		function new();
			settle_reg   = SETTLE_RST;
			trig_reg     = TRIGGER_RST;
			tmo_reg      = TIMEOUT_RST;
			phase        = PH_IDLE;
			count        = '0;
			tick_now     = '0;
			rise_at      = '0;
			fall_at      = '0;
			captured     = 1'b0;
			reading_held = 1'b0;
			echo_prev    = 1'b0;
			last_tmo     = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_SETTLE: settle_reg = data[SETTLE_W-1:0];
				REG_TRIGGER: trig_reg = data[TRIG_W-1:0];
				REG_TIMEOUT: tmo_reg = data[TMO_W-1:0];
				default: ;
			endcase
		endfunction

		function cnt_t bump(cnt_t c);
			return (c == CNT_MAX) ? c : c + 1'b1;
		endfunction

		function void take_tick(bit req, bit echo);
			result_t want;
			cnt_t    pulse_len;
			bit      tmo;
			pulse_len = (trig_reg == '0) ? cnt_t'(1) : cnt_t'(trig_reg);
			tmo = 1'b0;
			// edges stamp with the time before this tick's increment
			if (!captured) begin
				if (echo && !echo_prev)
					rise_at = tick_now;
				else if (!echo && echo_prev) begin
					fall_at = tick_now;
					captured = 1'b1;
				end
			end
			echo_prev = echo;
			case (phase)
				PH_SETTLE: begin
					count = bump(count);
					if (count >= settle_reg) begin
						phase = PH_TRIG;
						count = '0;
					end
				end
				PH_TRIG: begin
					count = bump(count);
					if (count >= pulse_len) begin
						phase = PH_WAIT;
						count = '0;
					end
				end
				PH_WAIT: begin
					if (captured) begin
						reading_held = 1'b1;
						phase = PH_IDLE;
						count = '0;
					end else begin
						count = bump(count);
						if (count > tmo_reg) begin
							tmo = 1'b1;
							phase = PH_SETTLE;
							count = '0;
						end
					end
				end
				default: begin
					phase = PH_IDLE;
					if (req) begin
						captured = 1'b0;
						reading_held = 1'b0;
						phase = PH_SETTLE;
						count = '0;
					end
				end
			endcase
			tick_now = tick_now + 1'b1;
			last_tmo = tmo;
			want.trigger_out = (phase == PH_TRIG);
			want.busy        = (phase != PH_IDLE);
			want.done        = reading_held;
			want.start_time  = rise_at;
			want.end_time    = fall_at;
			want.width       = fall_at - rise_at;
			want.timed_out   = tmo;
			due.push_back(want);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
		endfunction

		function void match_reading(result_t got);
			result_t want;
			if (due.size() == 0) begin
				flag("unexpected result", 32'd0, 32'd1);
				return;
			end
			want = due.pop_front();
			if (got.trigger_out !== want.trigger_out)
				flag("trigger_out", 32'(want.trigger_out), 32'(got.trigger_out));
			if (got.busy !== want.busy)
				flag("busy_res", 32'(want.busy), 32'(got.busy));
			if (got.done !== want.done)
				flag("done_res", 32'(want.done), 32'(got.done));
			if (got.start_time !== want.start_time)
				flag("echo_start_time", want.start_time, got.start_time);
			if (got.end_time !== want.end_time)
				flag("echo_end_time", want.end_time, got.end_time);
			if (got.width !== want.width)
				flag("pulse_width", want.width, got.width);
			if (got.timed_out !== want.timed_out)
				flag("timed_out", 32'(want.timed_out), 32'(got.timed_out));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        start_request;
	logic        echo_level;
	logic        out_valid;
	logic        out_ready;
	logic        trigger_out;
	logic        busy_res;
	logic        done_res;
	logic [31:0] echo_start_time;
	logic [31:0] echo_end_time;
	logic [31:0] pulse_width;
	logic        timed_out;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	cfg_data_t   cfg_data;

	reading_tracker tracker;
	int ticks_sent  = 0;
	int stall_left  = 0;
	bit steady_src  = 1'b0;
	bit steady_sink = 1'b0;

	ultrasonic_echo_ranger dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_request(start_request),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger_out(trigger_out),
		.busy_res(busy_res),
		.done_res(done_res),
		.echo_start_time(echo_start_time),
		.echo_end_time(echo_end_time),
		.pulse_width(pulse_width),
		.timed_out(timed_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : sink
		result_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen.trigger_out = trigger_out;
				seen.busy        = busy_res;
				seen.done        = done_res;
				seen.start_time  = echo_start_time;
				seen.end_time    = echo_end_time;
				seen.width       = pulse_width;
				seen.timed_out   = timed_out;
				tracker.match_reading(seen);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!steady_sink && $urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
		end
	end

	task automatic send_tick(bit req, bit echo);
		int gap;
		gap = steady_src ? 0 : idle_len();
		// drop valid only across a real gap; back-to-back ticks keep it high
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_request <= req;
		echo_level <= echo;
		do @(posedge clk); while (!in_ready);
		tracker.take_tick(req, echo);
		ticks_sent++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, cfg_data_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(cfg_data_t settle, cfg_data_t trig, cfg_data_t tmo);
		if ($urandom_range(0, 1)) begin
			write_cfg(REG_TIMEOUT, tmo);
			write_cfg(REG_TRIGGER, trig);
			write_cfg(REG_SETTLE, settle);
		end else begin
			write_cfg(REG_SETTLE, settle);
			write_cfg(REG_TRIGGER, trig);
			write_cfg(REG_TIMEOUT, tmo);
		end
	endtask

	// One measurement: echo pulse answers the wait, or arrives early (stale) in settle/trigger.
	task automatic run_measure(bit issue_request, int max_len);
		int     delay;
		int     hold;
		int     retries;
		int     max_delay;
		bit     stale;
		bit     echo;
		phase_t was;
		max_delay = (tracker.tmo_reg > 150) ? 150 : int'(tracker.tmo_reg) + 4;
		stale = (tracker.tmo_reg == '0) || ($urandom_range(0, 4) == 0);
		delay = 0;
		hold = 0;
		retries = 0;
		was = PH_IDLE;
		if (issue_request)
			send_tick(1'b1, stale ? 1'($urandom_range(0, 1)) : 1'b0);
		while (tracker.phase != PH_IDLE) begin
			if (tracker.last_tmo)
				retries++;
			// after a few retries fall back to an early pulse so the run ends
			if (retries >= 3)
				stale = 1'b1;
			if (tracker.phase == PH_WAIT) begin
				if (was != PH_WAIT) begin
					delay = $urandom_range(0, max_delay);
					hold = $urandom_range(1, max_len);
				end
				if (stale)
					echo = 1'b0;
				else if (delay > 0) begin
					echo = 1'b0;
					delay--;
				end else if (hold > 0) begin
					echo = 1'b1;
					hold--;
				end else
					echo = 1'b0;
			end else if (stale)
				echo = 1'($urandom_range(0, 1));
			else
				echo = ($urandom_range(0, 31) == 0);
			was = tracker.phase;
			// requests while busy must be ignored
			send_tick($urandom_range(0, 3) == 0, echo);
		end
	endtask

	initial begin
		int        stint;
		int        random_start;
		cfg_data_t trig_word;
		cfg_data_t tmo_word;
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_request = 1'b0;
		echo_level = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SETTLE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// echo edges while idle after reset are captured, later ones held off
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		wait_quiet();

		// zero settle, zero trigger width with upper data bits masked, zero timeout
		program_regs(20'd0, 20'hFFF00, 20'hF0000);
		run_measure(1'b1, 3);
		wait_quiet();
		program_regs(20'd2, 20'd1, 20'd1);
		write_cfg(REG_UNUSED, 20'hFFFFF);
		run_measure(1'b1, 1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		wait_quiet();

		// widest trigger and longest timeout
		program_regs(20'd1, 20'd255, 20'hFFFF);
		run_measure(1'b1, 30);
		wait_quiet();

		// full-scale settle, then cut it short while the block sits in settle
		program_regs(20'hFFFFF, 20'd3, 20'd20);
		send_tick(1'b1, 1'b0);
		repeat (40) send_tick(1'($urandom_range(0, 1)), 1'b0);
		wait_quiet();
		write_cfg(REG_SETTLE, 20'd5);
		run_measure(1'b0, 8);
		wait_quiet();

		random_start = ticks_sent;
		while (ticks_sent - random_start < 1000) begin
			steady_src = ($urandom_range(0, 3) == 0);
			steady_sink = ($urandom_range(0, 3) == 0);
			trig_word = cfg_data_t'($urandom);
			trig_word[TRIG_W-1:0] = trig_t'($urandom_range(0, 12));
			tmo_word = cfg_data_t'($urandom);
			tmo_word[TMO_W-1:0] = tmo_t'($urandom_range(0, 60));
			if ($urandom_range(0, 4) == 0)
				write_cfg(REG_UNUSED, cfg_data_t'($urandom));
			program_regs(cfg_data_t'($urandom_range(0, 30)), trig_word, tmo_word);
			stint = ticks_sent;
			while (ticks_sent - stint < 120) begin
				repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
				run_measure(1'b1, $urandom_range(1, 20));
			end
			wait_quiet();
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#30000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
